FILE: src/fcp_pkg.sv
// ----------------------------------------------------------------------------
// fcp_pkg: shared types and constants of the fly camera pose update core
// Fixed-point angle constants, datapath command codes and rounding helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package fcp_pkg;

  // Angles in Q.16 degrees
  localparam logic signed [41:0] HALF_TURN    = 42'sd11796480;
  localparam logic signed [41:0] FULL_TURN    = 42'sd23592960;
  localparam logic signed [41:0] PITCH_LIMIT  = 42'sd5832704;
  localparam logic signed [25:0] QUARTER_26   = 26'sd5898240;
  localparam logic signed [25:0] HALF_26      = 26'sd11796480;
  localparam logic signed [31:0] CORDIC_GAIN  = 32'sd163008218;
  localparam logic signed [31:0] ONE_Q28      = 32'sd268435456;
  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;
  localparam logic [4:0]         WRAP_TOP     = 5'd16;
  localparam logic [4:0]         MOVE_LAST    = 5'd5;
  localparam logic [4:0]         VEC_LAST     = 5'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_MOVE_SPEED  = 3'd0;
  localparam logic [2:0] CFG_TURN_SENS   = 3'd1;
  localparam logic [2:0] CFG_START_YAW   = 3'd2;
  localparam logic [2:0] CFG_START_PITCH = 3'd3;
  localparam logic [2:0] CFG_START_X     = 3'd4;
  localparam logic [2:0] CFG_START_Y     = 3'd5;
  localparam logic [2:0] CFG_START_Z     = 3'd6;

  // Datapath operations
  typedef enum logic [3:0] {
    DP_NOP, DP_CAPTURE, DP_LOAD, DP_MDX, DP_MDY, DP_PITCH, DP_MOVE, DP_SAT,
    DP_WRAP, DP_WFIX, DP_CINIT, DP_CSTEP, DP_CFIN, DP_VEC, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [4:0] idx;
    logic       sel;
  } dp_cmd_t;

  typedef struct packed {
    logic restart;
    logic move_en;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic               opcode;
    logic               move_enable;
    logic               go_forward;
    logic               go_backward;
    logic               go_left;
    logic               go_right;
    logic               go_up;
    logic               go_down;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic [15:0]        frame_time;
  } cam_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } cam_out_t;

  // atan(2^-i) in Q.16 degrees
  function automatic logic signed [25:0] atan_deg(input logic [4:0] i);
    logic signed [25:0] v;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  // Round half away from zero, drop 14 fraction bits
  function automatic logic signed [63:0] rnd14(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + 64'd8192) >> 14;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Round half away from zero, drop 42 fraction bits
  function automatic logic signed [63:0] rnd42(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << 41)) >> 42;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  // Clamp to +-1.0 in Q1.14
  function automatic logic signed [15:0] clamp14(input logic signed [63:0] v);
    logic signed [15:0] r;
    if (v > 64'sd16384) r = ONE_Q14;
    else if (v < -64'sd16384) r = -ONE_Q14;
    else r = 16'(v);
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/fcp_ctrl.sv
// ----------------------------------------------------------------------------
// fcp_ctrl: sequencer of the fly camera pose update
// Steps the datapath through velocity, turn, move, yaw wrap, CORDIC and
// vector rebuild for one item at a time; a restart skips turn and move, and move also runs only when enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module fcp_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire fcp_pkg::dp_stat_t stat,
  output fcp_pkg::dp_cmd_t      cmd
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_LOAD  = 14'b00000000000010,
    S_MDX   = 14'b00000000000100,
    S_MDY   = 14'b00000000001000,
    S_PITCH = 14'b00000000010000,
    S_MOVE  = 14'b00000000100000,
    S_SAT   = 14'b00000001000000,
    S_WRAP  = 14'b00000010000000,
    S_WFIX  = 14'b00000100000000,
    S_CINIT = 14'b00001000000000,
    S_CSTEP = 14'b00010000000000,
    S_CFIN  = 14'b00100000000000,
    S_VEC   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       sel_r, sel_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequence the item and issue one datapath command a cycle
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    cmd.op    = fcp_pkg::DP_NOP;
    cmd.idx   = cnt_r;
    cmd.sel   = sel_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = fcp_pkg::DP_CAPTURE;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.op = fcp_pkg::DP_LOAD;
        if (stat.restart) begin
          state_nxt = S_WRAP;
          cnt_nxt   = fcp_pkg::WRAP_TOP;
        end else begin
          state_nxt = S_MDX;
        end
      end
      S_MDX: begin
        cmd.op    = fcp_pkg::DP_MDX;
        state_nxt = S_MDY;
      end
      S_MDY: begin
        cmd.op    = fcp_pkg::DP_MDY;
        state_nxt = S_PITCH;
      end
      S_PITCH: begin
        cmd.op = fcp_pkg::DP_PITCH;
        if (stat.move_en) begin
          state_nxt = S_MOVE;
          cnt_nxt   = '0;
        end else begin
          state_nxt = S_WRAP;
          cnt_nxt   = fcp_pkg::WRAP_TOP;
        end
      end
      S_MOVE: begin
        cmd.op = fcp_pkg::DP_MOVE;
        if (cnt_r == fcp_pkg::MOVE_LAST) state_nxt = S_SAT;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_SAT: begin
        cmd.op    = fcp_pkg::DP_SAT;
        state_nxt = S_WRAP;
        cnt_nxt   = fcp_pkg::WRAP_TOP;
      end
      S_WRAP: begin
        cmd.op = fcp_pkg::DP_WRAP;
        if (cnt_r == '0) state_nxt = S_WFIX;
        else cnt_nxt = cnt_r - 5'd1;
      end
      S_WFIX: begin
        cmd.op    = fcp_pkg::DP_WFIX;
        state_nxt = S_CINIT;
        sel_nxt   = 1'b0;
      end
      S_CINIT: begin
        cmd.op    = fcp_pkg::DP_CINIT;
        state_nxt = S_CSTEP;
        cnt_nxt   = '0;
      end
      S_CSTEP: begin
        cmd.op = fcp_pkg::DP_CSTEP;
        if (cnt_r == CORDIC_LAST) state_nxt = S_CFIN;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_CFIN: begin
        cmd.op = fcp_pkg::DP_CFIN;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_CINIT;
        end else begin
          state_nxt = S_VEC;
          cnt_nxt   = '0;
        end
      end
      S_VEC: begin
        cmd.op = fcp_pkg::DP_VEC;
        if (cnt_r == fcp_pkg::VEC_LAST) state_nxt = S_DONE;
        else cnt_nxt = cnt_r + 5'd1;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = fcp_pkg::DP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("controller state not one-hot");
  a_cnt_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CSTEP |-> cnt_r <= CORDIC_LAST)
    else $error("CORDIC step count overrun");
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_LOAD)
    else $error("accepted beat did not start a sequence");

endmodule
`default_nettype wire

FILE: src/fcp_dp.sv
// ----------------------------------------------------------------------------
// fcp_dp: datapath of the fly camera pose update
// Config registers, pose state, one shared multiplier, yaw wrap reducer,
// shared CORDIC rotator and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module fcp_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fcp_pkg::dp_cmd_t  cmd,
  output fcp_pkg::dp_stat_t      stat,
  input  wire fcp_pkg::cam_in_t  item,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fcp_pkg::cam_out_t      out_item
);

  // Configuration
  logic [31:0]        speed_r;
  logic [23:0]        sens_r;
  logic signed [24:0] syaw_r;
  logic signed [23:0] spitch_r;
  logic signed [31:0] spos_r [3];

  // Item and working registers
  fcp_pkg::cam_in_t   item_r;
  logic signed [63:0] p_r;
  logic [32:0]        vel_r;
  logic signed [41:0] t_r;
  logic signed [36:0] sum_r [3];
  logic signed [31:0] crx_r, cry_r;
  logic signed [25:0] crz_r;
  logic               flip_r;
  logic signed [29:0] sin_y_r, cos_y_r, sin_p_r, cos_p_r;

  // Pose state
  logic signed [24:0] yaw_r;
  logic signed [23:0] pitch_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [2];
  logic signed [15:0] up_r [3];

  fcp_pkg::cam_out_t  out_r;
  logic               out_valid_r;

  assign stat.restart  = item_r.opcode;
  assign stat.move_en  = item_r.move_enable;
  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_item      = out_r;

  // Shared multiplier operand select
  logic signed [33:0] ma;
  logic signed [29:0] mb;
  logic signed [15:0] comp;
  logic signed [63:0] prod;

  always_comb begin
    case (cmd.idx)
      5'd0: comp = front_r[0];
      5'd1: comp = front_r[1];
      5'd2: comp = front_r[2];
      5'd3: comp = right_r[0];
      5'd4: comp = right_r[1];
      default: comp = '0;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      fcp_pkg::DP_LOAD: begin
        ma = $signed({2'b00, speed_r});
        mb = $signed({14'd0, item_r.frame_time});
      end
      fcp_pkg::DP_MDX: begin
        ma = 34'(item_r.mouse_dx);
        mb = $signed({6'd0, sens_r});
      end
      fcp_pkg::DP_MDY: begin
        ma = 34'(item_r.mouse_dy);
        mb = $signed({6'd0, sens_r});
      end
      fcp_pkg::DP_MOVE: begin
        ma = $signed({1'b0, vel_r});
        mb = 30'(comp);
      end
      fcp_pkg::DP_VEC: begin
        ma = 34'(cmd.idx[0] ? sin_y_r : cos_y_r);
        mb = cmd.idx[1] ? sin_p_r : cos_p_r;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = 64'(ma) * 64'(mb);

  // Move term of the previous multiply
  logic [4:0]         term;
  logic signed [36:0] step;
  logic               pos_dir, neg_dir;
  logic [1:0]         dest;

  assign term = cmd.idx - 5'd1;
  assign step = 37'(fcp_pkg::rnd14(p_r));

  always_comb begin
    if (term < 5'd3) begin
      pos_dir = item_r.go_forward;
      neg_dir = item_r.go_backward;
      dest    = term[1:0];
    end else begin
      pos_dir = item_r.go_right;
      neg_dir = item_r.go_left;
      dest    = (term == 5'd3) ? 2'd0 : 2'd2;
    end
  end

  // Yaw wrap, CORDIC and vector helpers
  logic signed [41:0] fk, tfix, yaw_sum, pitch_sum;
  logic signed [25:0] ang, at;
  logic signed [31:0] cx_f, cy_f;
  logic signed [15:0] vq;
  logic signed [36:0] vel_s;

  assign fk        = fcp_pkg::FULL_TURN << cmd.idx;
  assign tfix      = (t_r < 0) ? t_r + fcp_pkg::FULL_TURN : t_r;
  assign yaw_sum   = 42'(yaw_r) + p_r[41:0] + fcp_pkg::HALF_TURN;
  assign pitch_sum = 42'(pitch_r) + p_r[41:0];
  assign ang       = cmd.sel ? 26'(pitch_r) : 26'(yaw_r);
  assign at        = fcp_pkg::atan_deg(cmd.idx);
  assign cx_f      = flip_r ? -crx_r : crx_r;
  assign cy_f      = flip_r ? -cry_r : cry_r;
  assign vq        = fcp_pkg::clamp14(fcp_pkg::rnd42(p_r));
  assign vel_s     = $signed({4'd0, vel_r});

  function automatic logic signed [29:0] clamp28(input logic signed [31:0] v);
    logic signed [29:0] r;
    if (v > fcp_pkg::ONE_Q28) r = 30'(fcp_pkg::ONE_Q28);
    else if (v < -fcp_pkg::ONE_Q28) r = 30'(-fcp_pkg::ONE_Q28);
    else r = 30'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= 32'd65536;
      sens_r    <= 24'd6554;
      syaw_r    <= '0;
      spitch_r  <= '0;
      spos_r[0] <= '0;
      spos_r[1] <= '0;
      spos_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fcp_pkg::CFG_MOVE_SPEED:  speed_r   <= cfg_data;
        fcp_pkg::CFG_TURN_SENS:   sens_r    <= cfg_data[23:0];
        fcp_pkg::CFG_START_YAW:   syaw_r    <= cfg_data[24:0];
        fcp_pkg::CFG_START_PITCH: spitch_r  <= cfg_data[23:0];
        fcp_pkg::CFG_START_X:     spos_r[0] <= cfg_data;
        fcp_pkg::CFG_START_Y:     spos_r[1] <= cfg_data;
        fcp_pkg::CFG_START_Z:     spos_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r      <= '0;
      pitch_r    <= '0;
      pos_r[0]   <= '0;
      pos_r[1]   <= '0;
      pos_r[2]   <= '0;
      front_r[0] <= fcp_pkg::ONE_Q14;
      front_r[1] <= '0;
      front_r[2] <= '0;
      right_r[0] <= '0;
      right_r[1] <= fcp_pkg::ONE_Q14;
    end else begin
      case (cmd.op)
        fcp_pkg::DP_LOAD: begin
          if (item_r.opcode) begin
            pos_r[0] <= spos_r[0];
            pos_r[1] <= spos_r[1];
            pos_r[2] <= spos_r[2];
            if (42'(spitch_r) > fcp_pkg::PITCH_LIMIT) pitch_r <= 24'(fcp_pkg::PITCH_LIMIT);
            else if (42'(spitch_r) < -fcp_pkg::PITCH_LIMIT)
              pitch_r <= 24'(-fcp_pkg::PITCH_LIMIT);
            else pitch_r <= spitch_r;
          end
        end
        fcp_pkg::DP_PITCH: begin
          if (pitch_sum > fcp_pkg::PITCH_LIMIT) pitch_r <= 24'(fcp_pkg::PITCH_LIMIT);
          else if (pitch_sum < -fcp_pkg::PITCH_LIMIT) pitch_r <= 24'(-fcp_pkg::PITCH_LIMIT);
          else pitch_r <= 24'(pitch_sum);
        end
        fcp_pkg::DP_SAT: begin
          pos_r[0] <= sat32(sum_r[0]);
          pos_r[1] <= sat32(sum_r[1]);
          pos_r[2] <= sat32(sum_r[2]);
        end
        fcp_pkg::DP_WFIX: yaw_r <= 25'(tfix - fcp_pkg::HALF_TURN);
        fcp_pkg::DP_VEC: begin
          if (cmd.idx == 5'd0) begin
            front_r[1] <= fcp_pkg::clamp14(fcp_pkg::rnd14(64'(sin_p_r)));
            right_r[0] <= fcp_pkg::clamp14(fcp_pkg::rnd14(-64'(sin_y_r)));
            right_r[1] <= fcp_pkg::clamp14(fcp_pkg::rnd14(64'(cos_y_r)));
          end
          if (cmd.idx == 5'd1) front_r[0] <= vq;
          if (cmd.idx == 5'd2) front_r[2] <= vq;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      fcp_pkg::DP_CAPTURE: item_r <= item;
      fcp_pkg::DP_LOAD: begin
        p_r <= prod;
        t_r <= 42'(syaw_r) + fcp_pkg::HALF_TURN;
      end
      fcp_pkg::DP_MDX: begin
        vel_r <= 33'((p_r + 64'sd32768) >>> 16);
        p_r   <= prod;
      end
      fcp_pkg::DP_MDY: begin
        t_r <= yaw_sum;
        p_r <= prod;
      end
      fcp_pkg::DP_PITCH: begin
        sum_r[0] <= 37'(pos_r[0]);
        sum_r[2] <= 37'(pos_r[2]);
        if (item_r.go_up && !item_r.go_down) sum_r[1] <= 37'(pos_r[1]) + vel_s;
        else if (item_r.go_down && !item_r.go_up) sum_r[1] <= 37'(pos_r[1]) - vel_s;
        else sum_r[1] <= 37'(pos_r[1]);
      end
      fcp_pkg::DP_MOVE: begin
        p_r <= prod;
        if (cmd.idx != 5'd0) begin
          if (pos_dir && !neg_dir) sum_r[dest] <= sum_r[dest] + step;
          else if (neg_dir && !pos_dir) sum_r[dest] <= sum_r[dest] - step;
        end
      end
      fcp_pkg::DP_WRAP: begin
        if (t_r >= fk) t_r <= t_r - fk;
        else if (t_r <= -fk) t_r <= t_r + fk;
      end
      fcp_pkg::DP_CINIT: begin
        crx_r <= fcp_pkg::CORDIC_GAIN;
        cry_r <= '0;
        if (ang > fcp_pkg::QUARTER_26) begin
          crz_r  <= ang - fcp_pkg::HALF_26;
          flip_r <= 1'b1;
        end else if (ang < -fcp_pkg::QUARTER_26) begin
          crz_r  <= ang + fcp_pkg::HALF_26;
          flip_r <= 1'b1;
        end else begin
          crz_r  <= ang;
          flip_r <= 1'b0;
        end
      end
      fcp_pkg::DP_CSTEP: begin
        if (crz_r >= 0) begin
          crx_r <= crx_r - (cry_r >>> cmd.idx);
          cry_r <= cry_r + (crx_r >>> cmd.idx);
          crz_r <= crz_r - at;
        end else begin
          crx_r <= crx_r + (cry_r >>> cmd.idx);
          cry_r <= cry_r - (crx_r >>> cmd.idx);
          crz_r <= crz_r + at;
        end
      end
      fcp_pkg::DP_CFIN: begin
        if (cmd.sel) begin
          cos_p_r <= clamp28(cx_f);
          sin_p_r <= clamp28(cy_f);
        end else begin
          cos_y_r <= clamp28(cx_f);
          sin_y_r <= clamp28(cy_f);
        end
      end
      fcp_pkg::DP_VEC: begin
        p_r <= prod;
        if (cmd.idx == 5'd0) up_r[1] <= fcp_pkg::clamp14(fcp_pkg::rnd14(64'(cos_p_r)));
        if (cmd.idx == 5'd3) up_r[0] <= -vq;
        if (cmd.idx == 5'd4) up_r[2] <= -vq;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.op == fcp_pkg::DP_OUT) begin
      out_r.pos_x   <= pos_r[0];
      out_r.pos_y   <= pos_r[1];
      out_r.pos_z   <= pos_r[2];
      out_r.front_x <= front_r[0];
      out_r.front_y <= front_r[1];
      out_r.front_z <= front_r[2];
      out_r.right_x <= right_r[0];
      out_r.right_z <= right_r[1];
      out_r.up_x    <= up_r[0];
      out_r.up_y    <= up_r[1];
      out_r.up_z    <= up_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.op == fcp_pkg::DP_OUT) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (yaw_r >= -25'sd11796480) && (yaw_r <= 25'sd11796479))
    else $error("yaw outside wrap range");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pitch_r >= -24'sd5832704) && (pitch_r <= 24'sd5832704))
    else $error("pitch outside clamp range");
  a_out_copy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == fcp_pkg::DP_OUT |=> out_valid_r && out_r.front_x == front_r[0])
    else $error("result beat not loaded from pose state");

endmodule
`default_nettype wire

FILE: src/fly_camera_pose_update_core.sv
// Path: a frame tick with movement also runs the move and saturate states, one without
// movement skips them, and a restart skips the turn states as well.
// Throughput: one item at a time; the next beat can be taken once the result is loaded.
// The rate is set by the shared CORDIC rotator (two angles) and the 17-step yaw wrap reducer.
// Reset (synchronous, rst_n low): config to defaults, pose to origin, front (1,0,0), right (0,1).
// ----------------------------------------------------------------------------
// fly_camera_pose_update_core: fixed-point Euler-angle fly camera
// Translates and turns, or restarts at the start pose, then rebuilds front, right and up vectors once per beat.
// ----------------------------------------------------------------------------
`default_nettype none
module fly_camera_pose_update_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_opcode,
  input  wire logic               in_move_enable,
  input  wire logic               in_go_forward,
  input  wire logic               in_go_backward,
  input  wire logic               in_go_left,
  input  wire logic               in_go_right,
  input  wire logic               in_go_up,
  input  wire logic               in_go_down,
  input  wire logic signed [15:0] in_mouse_dx,
  input  wire logic signed [15:0] in_mouse_dy,
  input  wire logic [15:0]        in_frame_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic signed [31:0]      out_pos_z,
  output logic signed [15:0]      out_front_x,
  output logic signed [15:0]      out_front_y,
  output logic signed [15:0]      out_front_z,
  output logic signed [15:0]      out_right_x,
  output logic signed [15:0]      out_right_z,
  output logic signed [15:0]      out_up_x,
  output logic signed [15:0]      out_up_y,
  output logic signed [15:0]      out_up_z,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  fcp_pkg::dp_cmd_t  cmd;
  fcp_pkg::dp_stat_t stat;
  fcp_pkg::cam_in_t  item;
  fcp_pkg::cam_out_t res;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  // Pack the input beat
  assign item.opcode      = in_opcode;
  assign item.move_enable = in_move_enable;
  assign item.go_forward  = in_go_forward;
  assign item.go_backward = in_go_backward;
  assign item.go_left     = in_go_left;
  assign item.go_right    = in_go_right;
  assign item.go_up       = in_go_up;
  assign item.go_down     = in_go_down;
  assign item.mouse_dx    = in_mouse_dx;
  assign item.mouse_dy    = in_mouse_dy;
  assign item.frame_time  = in_frame_time;

  fcp_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  fcp_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (res)
  );

  // Unpack the result beat
  assign out_pos_x   = res.pos_x;
  assign out_pos_y   = res.pos_y;
  assign out_pos_z   = res.pos_z;
  assign out_front_x = res.front_x;
  assign out_front_y = res.front_y;
  assign out_front_z = res.front_z;
  assign out_right_x = res.right_x;
  assign out_right_z = res.right_z;
  assign out_up_x    = res.up_x;
  assign out_up_y    = res.up_y;
  assign out_up_z    = res.up_z;

endmodule
`default_nettype wire

FILE: dv/tb_fly_camera_pose_update_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fly_camera_pose_update_core: self-checking bench of the fly camera core
// Drives frame ticks and restarts, predicts pose and basis vectors per beat
// with a fixed-point CORDIC model of its own and compares every result field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_fly_camera_pose_update_core;

  localparam int NSTEPS = 16;
  localparam longint HALF_T = 64'sd11796480;
  localparam longint FULL_T = 64'sd23592960;
  localparam longint QUART_T = 64'sd5898240;
  localparam longint PLIM = 64'sd5832704;
  localparam longint GAIN28 = 64'sd163008218;
  localparam longint UNIT28 = 64'sd268435456;
  localparam longint UNIT14 = 64'sd16384;
  localparam longint LIMIT_CYCLES = 64'd2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  fcp_pkg::cam_in_t item_q = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fcp_pkg::cam_out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  fly_camera_pose_update_core #(.CORDIC_STEPS(NSTEPS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(item_q.opcode), .in_move_enable(item_q.move_enable),
    .in_go_forward(item_q.go_forward), .in_go_backward(item_q.go_backward),
    .in_go_left(item_q.go_left), .in_go_right(item_q.go_right),
    .in_go_up(item_q.go_up), .in_go_down(item_q.go_down),
    .in_mouse_dx(item_q.mouse_dx), .in_mouse_dy(item_q.mouse_dy),
    .in_frame_time(item_q.frame_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(res.pos_x), .out_pos_y(res.pos_y), .out_pos_z(res.pos_z),
    .out_front_x(res.front_x), .out_front_y(res.front_y), .out_front_z(res.front_z),
    .out_right_x(res.right_x), .out_right_z(res.right_z),
    .out_up_x(res.up_x), .out_up_y(res.up_y), .out_up_z(res.up_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  longint speed_cfg, sens_cfg, yaw0_cfg, pitch0_cfg, x0_cfg, y0_cfg, z0_cfg;
  longint yaw_a, pitch_a;
  longint pos_v[3];
  longint front_v[3];
  longint right_v[2];
  fcp_pkg::cam_out_t pose_q[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;

  function automatic longint half_away(longint v, int s);
    longint m, r;
    m = (v < 0) ? -v : v;
    r = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint wrap_angle(longint v);
    longint t;
    t = (v + HALF_T) % FULL_T;
    if (t < 0) t += FULL_T;
    return t - HALF_T;
  endfunction

  function automatic longint arctan_q16(int i);
    longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return tbl[i];
  endfunction

  // Rotate the gain vector to the angle; returns sine and cosine in Q1.28
  task automatic cordic_sc(input longint a, output longint s, output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    flip = 1'b0;
    x = GAIN28;
    y = 0;
    if (a > QUART_T) begin
      a -= HALF_T; flip = 1'b1;
    end else if (a < -QUART_T) begin
      a += HALF_T; flip = 1'b1;
    end
    z = a;
    for (int i = 0; i < NSTEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_q16(i);
      end else begin
        x += dx; y -= dy; z += arctan_q16(i);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, -UNIT28, UNIT28);
    s = clip(y, -UNIT28, UNIT28);
  endtask

  function automatic longint q14_of(longint v);
    return clip(half_away(v, 14), -UNIT14, UNIT14);
  endfunction

  function automatic longint mul_q14(longint a, longint b);
    return clip(half_away(a * b, 42), -UNIT14, UNIT14);
  endfunction

  task automatic pose_reset();
    speed_cfg = 65536; sens_cfg = 6554;
    yaw0_cfg = 0; pitch0_cfg = 0; x0_cfg = 0; y0_cfg = 0; z0_cfg = 0;
    yaw_a = 0; pitch_a = 0;
    pos_v = '{0, 0, 0};
    front_v = '{UNIT14, 0, 0};
    right_v = '{0, UNIT14};
  endtask

  // Work out the pose after one beat and queue it
  task automatic predict_pose(input fcp_pkg::cam_in_t it);
    longint vel, sum[3], st, sx, sz, sy, cy, sp, cp;
    fcp_pkg::cam_out_t r;
    if (it.opcode) begin
      pos_v = '{x0_cfg, y0_cfg, z0_cfg};
      yaw_a = wrap_angle(yaw0_cfg);
      pitch_a = clip(pitch0_cfg, -PLIM, PLIM);
    end else begin
      vel = (speed_cfg * longint'(it.frame_time) + 32768) >>> 16;
      if (it.move_enable) begin
        for (int k = 0; k < 3; k++) begin
          sum[k] = pos_v[k];
          st = half_away(vel * front_v[k], 14);
          if (it.go_forward) sum[k] += st;
          if (it.go_backward) sum[k] -= st;
        end
        sx = half_away(vel * right_v[0], 14);
        sz = half_away(vel * right_v[1], 14);
        if (it.go_left) begin
          sum[0] -= sx; sum[2] -= sz;
        end
        if (it.go_right) begin
          sum[0] += sx; sum[2] += sz;
        end
        if (it.go_up) sum[1] += vel;
        if (it.go_down) sum[1] -= vel;
        for (int k = 0; k < 3; k++)
          pos_v[k] = clip(sum[k], -64'sd2147483648, 64'sd2147483647);
      end
      yaw_a = wrap_angle(yaw_a + longint'(it.mouse_dx) * sens_cfg);
      pitch_a = clip(pitch_a + longint'(it.mouse_dy) * sens_cfg, -PLIM, PLIM);
    end
    cordic_sc(yaw_a, sy, cy);
    cordic_sc(pitch_a, sp, cp);
    front_v[0] = mul_q14(cy, cp);
    front_v[1] = q14_of(sp);
    front_v[2] = mul_q14(sy, cp);
    right_v[0] = q14_of(-sy);
    right_v[1] = q14_of(cy);
    r.pos_x = 32'(pos_v[0]); r.pos_y = 32'(pos_v[1]); r.pos_z = 32'(pos_v[2]);
    r.front_x = 16'(front_v[0]); r.front_y = 16'(front_v[1]); r.front_z = 16'(front_v[2]);
    r.right_x = 16'(right_v[0]); r.right_z = 16'(right_v[1]);
    r.up_x = 16'(mul_q14(-cy, sp)); r.up_y = 16'(q14_of(cp));
    r.up_z = 16'(mul_q14(-sy, sp));
    pose_q.push_back(r);
  endtask

  // Sender burst pacing
  int burst_left = 0;

  task automatic send_beat(input fcp_pkg::cam_in_t it);
    int gap;
    cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    item_q <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_pose(it);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      fcp_pkg::CFG_MOVE_SPEED:  speed_cfg = longint'(val);
      fcp_pkg::CFG_TURN_SENS:   sens_cfg = longint'(val[23:0]);
      fcp_pkg::CFG_START_YAW:   yaw0_cfg = longint'($signed(val[24:0]));
      fcp_pkg::CFG_START_PITCH: pitch0_cfg = longint'($signed(val[23:0]));
      fcp_pkg::CFG_START_X:     x0_cfg = longint'($signed(val));
      fcp_pkg::CFG_START_Y:     y0_cfg = longint'($signed(val));
      fcp_pkg::CFG_START_Z:     z0_cfg = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic fcp_pkg::cam_in_t rand_item(int restart_pct);
    fcp_pkg::cam_in_t it;
    it = fcp_pkg::cam_in_t'(56'({$urandom, $urandom}));
    it.opcode = ($urandom_range(0, 99) < restart_pct);
    case ($urandom_range(0, 3))
      0: it.mouse_dx = 16'($urandom_range(0, 40) - 20);
      1: it.mouse_dx = 16'($urandom);
      default: it.mouse_dx = 16'($urandom_range(0, 400) - 200);
    endcase
    if ($urandom_range(0, 3) != 0) it.mouse_dy = 16'($urandom_range(0, 200) - 100);
    return it;
  endfunction

  function automatic fcp_pkg::cam_in_t tick(bit en, logic [5:0] flags, int dx, int dy, int ft);
    fcp_pkg::cam_in_t it;
    it = '0;
    it.move_enable = en;
    {it.go_forward, it.go_backward, it.go_left, it.go_right, it.go_up, it.go_down} = flags;
    it.mouse_dx = 16'(dx);
    it.mouse_dy = 16'(dy);
    it.frame_time = 16'(ft);
    return it;
  endfunction

  // Directed: each flag, opposing flags, frozen move, pitch clamp, yaw wrap, restart
  task automatic test_directed();
    fcp_pkg::cam_in_t r;
    r = '0;
    r.opcode = 1'b1;
    for (int b = 0; b < 6; b++) send_beat(tick(1'b1, 6'(1 << b), 0, 0, 32'hFFFF));
    send_beat(tick(1'b1, 6'b111111, 0, 0, 32'h8000));
    send_beat(tick(1'b0, 6'b101010, 100, -50, 32'hFFFF));
    send_beat(tick(1'b1, 6'b100000, 0, 32767, 32'h4000));
    send_beat(tick(1'b1, 6'b010000, 0, -32768, 32'h4000));
    send_beat(tick(1'b0, 6'b0, 32767, 0, 0));
    send_beat(tick(1'b0, 6'b0, -32768, 0, 0));
    send_beat(tick(1'b1, 6'b000100, -32768, 0, 0));
    send_beat(r);
    drain();
  endtask

  task automatic test_config_extremes();
    fcp_pkg::cam_in_t r;
    r = '0;
    r.opcode = 1'b1;
    write_reg(fcp_pkg::CFG_MOVE_SPEED, 32'hFFFF_FFFF);
    write_reg(fcp_pkg::CFG_TURN_SENS, 32'h00FF_FFFF);
    write_reg(fcp_pkg::CFG_START_YAW, 32'(-11796480));
    write_reg(fcp_pkg::CFG_START_PITCH, 32'(5832704));
    write_reg(fcp_pkg::CFG_START_X, 32'h7FFF_FFF0);
    write_reg(fcp_pkg::CFG_START_Y, 32'h8000_0010);
    write_reg(fcp_pkg::CFG_START_Z, 32'h7FFF_FFFF);
    send_beat(r);
    send_beat(tick(1'b1, 6'b101001, 1, -1, 32'hFFFF));
    send_beat(tick(1'b1, 6'b010110, -1, 1, 32'hFFFF));
    drain();
    write_reg(fcp_pkg::CFG_START_YAW, 32'(11796479));
    write_reg(fcp_pkg::CFG_START_PITCH, 32'(-5832704));
    write_reg(fcp_pkg::CFG_START_X, 32'h8000_0000);
    send_beat(r);
    send_beat(tick(1'b1, 6'b011000, 3, 3, 32'hFFFF));
    drain();
    write_reg(fcp_pkg::CFG_MOVE_SPEED, 32'd0);
    write_reg(fcp_pkg::CFG_TURN_SENS, 32'd0);
    write_reg(fcp_pkg::CFG_START_PITCH, 32'h00FF_FFFF);
    send_beat(r);
    send_beat(tick(1'b1, 6'b111111, 500, 500, 32'hFFFF));
    drain();
  endtask

  task automatic test_random(int count);
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(fcp_pkg::CFG_MOVE_SPEED,
                (ph == 3) ? $urandom : $urandom_range(0, 32'h0040_0000));
      write_reg(fcp_pkg::CFG_TURN_SENS, (ph == 2) ? $urandom_range(0, 32'h00FF_FFFF)
                                                  : $urandom_range(0, 200000));
      write_reg(fcp_pkg::CFG_START_YAW, $urandom);
      write_reg(fcp_pkg::CFG_START_PITCH, $urandom);
      write_reg(fcp_pkg::CFG_START_X, $urandom);
      write_reg(fcp_pkg::CFG_START_Y, $urandom);
      write_reg(fcp_pkg::CFG_START_Z, $urandom);
      for (int n = 0; n < count / 4; n++) send_beat(rand_item(8));
      drain();
    end
  endtask

  // Hold the result side off long enough for the core to fill and stall
  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int n = 0; n < 6; n++) send_beat(rand_item(10));
    long_hold = 1'b0;
    drain();
  endtask

  initial begin
    pose_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random(1280);
    if (errors == 0) begin
      $display("fly_camera_pose_update_core: match");
    end else begin
      $display("fly_camera_pose_update_core: mismatch");
    end
    $finish;
  end

  // Receiver stall pattern, with a long hold-off on request
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (long_hold) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= (hold_cnt > 400);
    end else begin
      hold_cnt <= 0;
      out_ready <= (cycles[9:8] == 2'b00) || ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    fcp_pkg::cam_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pose_q.size() == 0) begin
        $error("unexpected result beat");
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (res.pos_x !== e.pos_x) begin
          $error("pos_x exp %0d got %0d", e.pos_x, res.pos_x); errors++;
        end
        if (res.pos_y !== e.pos_y) begin
          $error("pos_y exp %0d got %0d", e.pos_y, res.pos_y); errors++;
        end
        if (res.pos_z !== e.pos_z) begin
          $error("pos_z exp %0d got %0d", e.pos_z, res.pos_z); errors++;
        end
        if (res.front_x !== e.front_x) begin
          $error("front_x exp %0d got %0d", e.front_x, res.front_x); errors++;
        end
        if (res.front_y !== e.front_y) begin
          $error("front_y exp %0d got %0d", e.front_y, res.front_y); errors++;
        end
        if (res.front_z !== e.front_z) begin
          $error("front_z exp %0d got %0d", e.front_z, res.front_z); errors++;
        end
        if (res.right_x !== e.right_x) begin
          $error("right_x exp %0d got %0d", e.right_x, res.right_x); errors++;
        end
        if (res.right_z !== e.right_z) begin
          $error("right_z exp %0d got %0d", e.right_z, res.right_z); errors++;
        end
        if (res.up_x !== e.up_x) begin
          $error("up_x exp %0d got %0d", e.up_x, res.up_x); errors++;
        end
        if (res.up_y !== e.up_y) begin
          $error("up_y exp %0d got %0d", e.up_y, res.up_y); errors++;
        end
        if (res.up_z !== e.up_z) begin
          $error("up_z exp %0d got %0d", e.up_z, res.up_z); errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("fly_camera_pose_update_core: mismatch");
      $finish;
    end
  end

endmodule
`default_nettype wire
